// ===== rtl/tblf_pkg.sv =====
// Shared types and constants for the twin bright line target finder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package tblf_pkg;

    localparam int FRAME_WIDTH  = 160;
    localparam int FRAME_HEIGHT = 120;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int RUN_W  = 8;   // signed row index, -1 means no run
    localparam int THR_W  = 9;
    localparam int MIN_W  = 7;
    localparam int SQ_W   = 18;  // holds 3 * 255^2 and 511^2
    localparam int CH_SQ_W = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);
    localparam logic [RUN_W-1:0] NO_RUN   = '1;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_THRESH   = 3'd0;
    localparam logic [2:0] REG_MIN_RUN  = 3'd1;
    localparam logic [2:0] REG_LINE_MAX = 3'd2;
    localparam logic [2:0] REG_GAP_MIN  = 3'd3;
    localparam logic [2:0] REG_GAP_MAX  = 3'd4;

    localparam logic [THR_W-1:0] THRESH_RST   = 9'd250;
    localparam logic [MIN_W-1:0] MIN_RUN_RST  = 7'd20;
    localparam logic [COL_W-1:0] LINE_MAX_RST = 8'd5;
    localparam logic [COL_W-1:0] GAP_MIN_RST  = 8'd10;
    localparam logic [COL_W-1:0] GAP_MAX_RST  = 8'd60;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic             bright_pixel;
        logic             frame_done;
        logic             target_found;
        logic [COL_W-1:0] box_left;
        logic [COL_W-1:0] box_right;
        logic [ROW_W-1:0] box_top;
        logic [ROW_W-1:0] box_bottom;
    } t_pix_out;

    typedef struct packed {
        logic [THR_W-1:0] brightness_threshold;
        logic [MIN_W-1:0] min_run_rows;
        logic [COL_W-1:0] line_width_max;
        logic [COL_W-1:0] gap_width_min;
        logic [COL_W-1:0] gap_width_max;
    } t_cfg;

    typedef enum logic [4:0] {
        SC_LEFT  = 5'b00001,
        SC_GAP   = 5'b00010,
        SC_RIGHT = 5'b00100,
        SC_END   = 5'b01000,
        SC_DONE  = 5'b10000
    } t_scan_state;

endpackage

// ===== rtl/tblf_bright.sv =====
// Brightness datapath: input register, channel squares, threshold compare.
// Depends on tblf_pkg.
`timescale 1ns / 1ps

module tblf_bright (
    input  logic                       i_clk,
    input  logic                       i_ld1,
    input  logic                       i_ld2,
    input  logic                       i_ld3,
    input  tblf_pkg::t_pix_in          i_pix,
    input  logic [tblf_pkg::SQ_W-1:0]  i_thr_sq,
    output logic                       o_lit,
    output logic                       o_frame_start
);

    tblf_pkg::t_pix_in                r_pix;
    logic [tblf_pkg::CH_SQ_W-1:0]     r_sq_b;
    logic [tblf_pkg::CH_SQ_W-1:0]     r_sq_g;
    logic [tblf_pkg::CH_SQ_W-1:0]     r_sq_r;
    logic                             r_fs2;
    logic                             r_lit3;
    logic                             r_fs3;
    logic [tblf_pkg::SQ_W-1:0]        sum_sq;

    assign sum_sq = tblf_pkg::SQ_W'(r_sq_b) + tblf_pkg::SQ_W'(r_sq_g)
                  + tblf_pkg::SQ_W'(r_sq_r);

    always_ff @(posedge i_clk) begin
        if (i_ld1) begin
            r_pix <= i_pix;
        end
        if (i_ld2) begin
            r_sq_b <= tblf_pkg::CH_SQ_W'(r_pix.blue)  * tblf_pkg::CH_SQ_W'(r_pix.blue);
            r_sq_g <= tblf_pkg::CH_SQ_W'(r_pix.green) * tblf_pkg::CH_SQ_W'(r_pix.green);
            r_sq_r <= tblf_pkg::CH_SQ_W'(r_pix.red)   * tblf_pkg::CH_SQ_W'(r_pix.red);
            r_fs2  <= r_pix.frame_start;
        end
        if (i_ld3) begin
            r_lit3 <= (sum_sq > i_thr_sq);
            r_fs3  <= r_fs2;
        end
    end

    assign o_lit         = r_lit3;
    assign o_frame_start = r_fs3;

endmodule

// ===== rtl/tblf_scan.sv =====
// Row scanner, run tracker and bounding box for one pixel per step.
// Depends on tblf_pkg.
`timescale 1ns / 1ps

module tblf_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_lit,
    input  logic                i_frame_start,
    input  tblf_pkg::t_cfg      i_cfg,
    output tblf_pkg::t_pix_out  o_res
);

    logic [tblf_pkg::COL_W-1:0] r_col, n_col;
    logic [tblf_pkg::ROW_W-1:0] r_row, n_row;
    tblf_pkg::t_scan_state      r_state, n_state;
    logic [tblf_pkg::COL_W-1:0] r_ls, n_ls, r_lsp, n_lsp, r_rs, n_rs, r_rsp, n_rsp;
    logic [tblf_pkg::RUN_W-1:0] r_first, n_first, r_last, n_last;
    logic [tblf_pkg::COL_W-1:0] r_bleft, n_bleft, r_bright, n_bright;
    logic [tblf_pkg::ROW_W-1:0] r_btop, n_btop, r_bbot, n_bbot;
    logic                       r_stop, n_stop;

    logic [tblf_pkg::COL_W-1:0] col_e, row_ls, row_lsp, row_rs, row_rsp;
    logic [tblf_pkg::COL_W-1:0] d_left, d_gap, d_right;
    logic [tblf_pkg::ROW_W-1:0] row_e;
    tblf_pkg::t_scan_state      row_state;
    logic [tblf_pkg::RUN_W-1:0] first_e, last_e;
    logic signed [tblf_pkg::RUN_W:0] run_old, run_new, min_s;
    logic                       row_end, frame_end, row_match, found;

    always_comb begin
        // frame start clears counters, run, box and stop flag before the pixel is used
        col_e   = i_frame_start ? '0 : r_col;
        row_e   = i_frame_start ? '0 : r_row;
        first_e = i_frame_start ? tblf_pkg::NO_RUN : r_first;
        last_e  = i_frame_start ? tblf_pkg::NO_RUN : r_last;
        n_bleft  = i_frame_start ? '0 : r_bleft;
        n_bright = i_frame_start ? '0 : r_bright;
        n_btop   = i_frame_start ? '0 : r_btop;
        n_bbot   = i_frame_start ? '0 : r_bbot;
        n_stop   = i_frame_start ? 1'b0 : r_stop;

        row_state = (col_e == '0) ? tblf_pkg::SC_LEFT : r_state;
        row_ls    = (col_e == '0) ? '0 : r_ls;
        row_lsp   = (col_e == '0) ? '0 : r_lsp;
        row_rs    = (col_e == '0) ? '0 : r_rs;
        row_rsp   = (col_e == '0) ? '0 : r_rsp;

        // columns only grow within a row, so these never wrap
        d_left  = col_e - row_ls;
        d_gap   = col_e - row_lsp;
        d_right = col_e - row_rs;

        n_state = row_state;
        n_ls    = row_ls;
        n_lsp   = row_lsp;
        n_rs    = row_rs;
        n_rsp   = row_rsp;

        case (row_state)
            tblf_pkg::SC_LEFT: begin
                if (i_lit) begin
                    n_ls    = col_e;
                    n_state = tblf_pkg::SC_GAP;
                end
            end
            tblf_pkg::SC_GAP: begin
                if (!i_lit) begin
                    if (d_left <= i_cfg.line_width_max) begin
                        n_lsp   = col_e;
                        n_state = tblf_pkg::SC_RIGHT;
                    end else begin
                        n_ls    = '0;
                        n_state = tblf_pkg::SC_LEFT;
                    end
                end
            end
            tblf_pkg::SC_RIGHT: begin
                if (i_lit) begin
                    if (d_gap > i_cfg.gap_width_min && d_gap < i_cfg.gap_width_max) begin
                        n_rs    = col_e;
                        n_state = tblf_pkg::SC_END;
                    end else begin
                        // out-of-range gap: this pixel opens a new left line
                        n_ls    = col_e;
                        n_lsp   = '0;
                        n_state = tblf_pkg::SC_GAP;
                    end
                end
            end
            tblf_pkg::SC_END: begin
                if (!i_lit) begin
                    if (d_right <= i_cfg.line_width_max) begin
                        n_rsp   = col_e;
                        n_state = tblf_pkg::SC_DONE;
                    end else begin
                        n_ls    = '0;
                        n_lsp   = '0;
                        n_rs    = '0;
                        n_state = tblf_pkg::SC_LEFT;
                    end
                end
            end
            default: begin
            end
        endcase

        row_end   = (col_e >= tblf_pkg::LAST_COL);
        frame_end = row_end && (row_e >= tblf_pkg::LAST_ROW);
        row_match = (n_ls != '0) && (n_lsp != '0) && (n_rs != '0) && (n_rsp != '0);
        min_s     = $signed({2'b00, i_cfg.min_run_rows});
        run_old   = $signed({last_e[tblf_pkg::RUN_W-1], last_e})
                  - $signed({first_e[tblf_pkg::RUN_W-1], first_e});

        n_first = first_e;
        n_last  = last_e;
        if (row_end && !n_stop) begin
            if (row_match) begin
                if (first_e[tblf_pkg::RUN_W-1]) begin
                    n_first = {1'b0, row_e};
                    n_btop  = row_e;
                    n_bleft = n_ls;
                end
                n_last   = {1'b0, row_e};
                n_bbot   = row_e;
                n_bright = n_rs;
            end else if (run_old < min_s) begin
                n_first = tblf_pkg::NO_RUN;
                n_last  = '0;
            end else begin
                n_stop = 1'b1;
            end
        end

        run_new = $signed({n_last[tblf_pkg::RUN_W-1], n_last})
                - $signed({n_first[tblf_pkg::RUN_W-1], n_first});
        found   = (run_new >= min_s);

        o_res.bright_pixel = i_lit;
        o_res.frame_done   = frame_end;
        o_res.target_found = frame_end && found;
        o_res.box_left     = frame_end ? n_bleft  : '0;
        o_res.box_right    = frame_end ? n_bright : '0;
        o_res.box_top      = frame_end ? n_btop   : '0;
        o_res.box_bottom   = frame_end ? n_bbot   : '0;

        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : row_e + 1'b1;
        end else begin
            n_col = col_e + 1'b1;
            n_row = row_e;
        end

        if (frame_end) begin
            n_first  = tblf_pkg::NO_RUN;
            n_last   = tblf_pkg::NO_RUN;
            n_bleft  = '0;
            n_bright = '0;
            n_btop   = '0;
            n_bbot   = '0;
            n_stop   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_state  <= tblf_pkg::SC_LEFT;
            r_ls     <= '0;
            r_lsp    <= '0;
            r_rs     <= '0;
            r_rsp    <= '0;
            r_first  <= tblf_pkg::NO_RUN;
            r_last   <= tblf_pkg::NO_RUN;
            r_bleft  <= '0;
            r_bright <= '0;
            r_btop   <= '0;
            r_bbot   <= '0;
            r_stop   <= 1'b0;
        end else if (i_step) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_state  <= n_state;
            r_ls     <= n_ls;
            r_lsp    <= n_lsp;
            r_rs     <= n_rs;
            r_rsp    <= n_rsp;
            r_first  <= n_first;
            r_last   <= n_last;
            r_bleft  <= n_bleft;
            r_bright <= n_bright;
            r_btop   <= n_btop;
            r_bbot   <= n_bbot;
            r_stop   <= n_stop;
        end
    end

endmodule

// ===== rtl/twin_bright_line_target_finder.sv =====
// Top level: APB register file, pixel pipeline and output register.
// Depends on tblf_pkg, tblf_bright and tblf_scan.
// Pixel path: input register, channel squares, threshold compare, scan, then the output register.
// Throughput: one pixel per cycle; a full stage holds while the next stage is full and stalled.
// Reset (synchronous, active low): pipeline empties, registers return to their defaults,
// counters, row scan, run and box clear.
`timescale 1ns / 1ps

module twin_bright_line_target_finder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tblf_pkg::t_pix_in             i_pix,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tblf_pkg::t_pix_out            o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tblf_pkg::ADDR_W-1:0]   paddr,
    input  logic [tblf_pkg::DATA_W-1:0]   pwdata,
    output logic [tblf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    tblf_pkg::t_cfg              r_cfg;
    logic [tblf_pkg::SQ_W-1:0]   r_thr_sq;
    logic                        r_v1, r_v2, r_v3, r_vo;
    tblf_pkg::t_pix_out          r_out;
    tblf_pkg::t_pix_out          scan_res;
    logic                        adv1, adv2, adv3, adv_o;
    logic                        lit, frame_start;
    logic [2:0]                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness_threshold <= tblf_pkg::THRESH_RST;
            r_cfg.min_run_rows         <= tblf_pkg::MIN_RUN_RST;
            r_cfg.line_width_max       <= tblf_pkg::LINE_MAX_RST;
            r_cfg.gap_width_min        <= tblf_pkg::GAP_MIN_RST;
            r_cfg.gap_width_max        <= tblf_pkg::GAP_MAX_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tblf_pkg::REG_THRESH:   r_cfg.brightness_threshold <= pwdata[tblf_pkg::THR_W-1:0];
                tblf_pkg::REG_MIN_RUN:  r_cfg.min_run_rows         <= pwdata[tblf_pkg::MIN_W-1:0];
                tblf_pkg::REG_LINE_MAX: r_cfg.line_width_max       <= pwdata[tblf_pkg::COL_W-1:0];
                tblf_pkg::REG_GAP_MIN:  r_cfg.gap_width_min        <= pwdata[tblf_pkg::COL_W-1:0];
                tblf_pkg::REG_GAP_MAX:  r_cfg.gap_width_max        <= pwdata[tblf_pkg::COL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tblf_pkg::REG_THRESH:   prdata = tblf_pkg::DATA_W'(r_cfg.brightness_threshold);
            tblf_pkg::REG_MIN_RUN:  prdata = tblf_pkg::DATA_W'(r_cfg.min_run_rows);
            tblf_pkg::REG_LINE_MAX: prdata = tblf_pkg::DATA_W'(r_cfg.line_width_max);
            tblf_pkg::REG_GAP_MIN:  prdata = tblf_pkg::DATA_W'(r_cfg.gap_width_min);
            tblf_pkg::REG_GAP_MAX:  prdata = tblf_pkg::DATA_W'(r_cfg.gap_width_max);
            default:                prdata = '0;
        endcase
    end

    // threshold squared tracks the register in the cycle after it changes
    always_ff @(posedge i_clk) begin
        r_thr_sq <= tblf_pkg::SQ_W'(r_cfg.brightness_threshold)
                  * tblf_pkg::SQ_W'(r_cfg.brightness_threshold);
    end

    // a stage moves when it is empty or the one after it moves
    assign adv_o   = !r_vo || !i_stall;
    assign adv3    = !r_v3 || adv_o;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1)  r_v1 <= i_valid;
            if (adv2)  r_v2 <= r_v1;
            if (adv3)  r_v3 <= r_v2;
            if (adv_o) r_vo <= r_v3;
        end
    end

    tblf_bright u_bright (
        .i_clk         (i_clk),
        .i_ld1         (adv1 && i_valid),
        .i_ld2         (adv2 && r_v1),
        .i_ld3         (adv3 && r_v2),
        .i_pix         (i_pix),
        .i_thr_sq      (r_thr_sq),
        .o_lit         (lit),
        .o_frame_start (frame_start)
    );

    tblf_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv_o && r_v3),
        .i_lit         (lit),
        .i_frame_start (frame_start),
        .i_cfg         (r_cfg),
        .o_res         (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (adv_o && r_v3) begin
            r_out <= scan_res;
        end
    end

    assign o_valid = r_vo;
    assign o_res   = r_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_vo))
        else $error("input stalled with an empty pipeline stage");

    a_box_zero_off_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.frame_done) |-> (!o_res.target_found && o_res.box_left == '0
            && o_res.box_right == '0 && o_res.box_top == '0 && o_res.box_bottom == '0))
        else $error("box fields nonzero on a beat that does not end a frame");

    a_box_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.frame_done) |-> (o_res.box_bottom >= o_res.box_top))
        else $error("box bottom row above box top row");

endmodule
